@@ hw/rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, round constants and index helpers for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef logic [3:0][31:0] words4_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam words4_t CHAIN_IV = {IV_D, IV_C, IV_B, IV_A};

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] PAD_LIMIT  = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_WORD  = 2'd3;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAD,
    S_CLR,
    S_LEN,
    S_LOAD,
    S_MIX,
    S_STEP,
    S_ACCUM,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    FIN_DATA,
    FIN_PAD,
    FIN_LAST
  } fin_t;

  typedef enum logic [2:0] {
    BLK_NOP,
    BLK_BYTE,
    BLK_PAD,
    BLK_CLR,
    BLK_LEN
  } blk_op_t;

  typedef enum logic [2:0] {
    CORE_HOLD,
    CORE_LOAD,
    CORE_MIX,
    CORE_STEP,
    CORE_ACCUM,
    CORE_INIT
  } core_op_t;

  typedef struct packed {
    blk_op_t     op;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] len;
  } blk_ctl_t;

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] n;
    logic [3:0] idx;
    n = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = n;
      2'd1:    idx = 4'(n * 4'd5 + 4'd1);
      2'd2:    idx = 4'(n * 4'd3 + 4'd5);
      default: idx = 4'(n * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] wide;
    wide = {v, v} << s;
    return wide[63:32];
  endfunction

endpackage

@@ hw/rtl/md5_blkbuf.sv @@
// ----------------------------------------------------------------------------
// MD5 block buffer
// Sixteen little-endian message words with byte insert, pad, clear and
// length write operations, and one read port for the round unit.
// ----------------------------------------------------------------------------
module md5_blkbuf (
  input  logic             clk,
  input  md5_pkg::blk_ctl_t ctl_i,
  input  logic [3:0]       rd_idx_i,
  output logic [31:0]      rd_data_o
);
  import md5_pkg::*;

  logic [31:0] words_r [16];
  logic [31:0] ins_word;
  logic [3:0]  wsel;

  assign wsel     = ctl_i.pos[5:2];
  assign ins_word = 32'(ctl_i.data) << {ctl_i.pos[1:0], 3'b000};

  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      unique case (ctl_i.op) inside
        BLK_BYTE, BLK_PAD: begin
          if (4'(w) == wsel) begin
            if (ctl_i.pos[1:0] == 2'd0) begin
              words_r[w] <= ins_word;
            end else begin
              words_r[w] <= words_r[w] | ins_word;
            end
          end else if (ctl_i.op == BLK_PAD && 4'(w) > wsel) begin
            words_r[w] <= '0;
          end
        end
        BLK_CLR: begin
          words_r[w] <= '0;
        end
        BLK_LEN: begin
          if (4'(w) == LEN_LO_WORD) begin
            words_r[w] <= ctl_i.len[31:0];
          end else if (4'(w) == LEN_HI_WORD) begin
            words_r[w] <= ctl_i.len[63:32];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_data_o = words_r[rd_idx_i];

endmodule

@@ hw/rtl/md5_core.sv @@
// ----------------------------------------------------------------------------
// MD5 round unit
// Chaining words and working registers; one shared round datapath that
// runs in two steps per round (message and constant sum, then mix).
// ----------------------------------------------------------------------------
module md5_core (
  input  logic              clk,
  input  logic              rst_n,
  input  md5_pkg::core_op_t op_i,
  input  logic [5:0]        round_i,
  input  logic [31:0]       msg_i,
  output md5_pkg::words4_t  chain_o
);
  import md5_pkg::*;

  words4_t     chain_r;
  logic [31:0] a_r, b_r, c_r, d_r, t_r;
  logic [31:0] f_val;
  logic [31:0] t_nxt;
  logic [31:0] mix;
  logic [31:0] b_nxt;

  always_comb begin
    case (round_i[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
    t_nxt = a_r + SINE_K[round_i] + msg_i;
    mix   = t_r + f_val;
    b_nxt = b_r + rotl32(mix, ROT_S[{round_i[5:4], round_i[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= CHAIN_IV;
    end else begin
      unique case (op_i)
        CORE_INIT: chain_r <= CHAIN_IV;
        CORE_ACCUM: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op_i)
      CORE_LOAD: begin
        a_r <= chain_r[0];
        b_r <= chain_r[1];
        c_r <= chain_r[2];
        d_r <= chain_r[3];
      end
      CORE_MIX: t_r <= t_nxt;
      CORE_STEP: begin
        a_r <= d_r;
        b_r <= b_nxt;
        c_r <= b_r;
        d_r <= c_r;
      end
      default: begin
      end
    endcase
  end

  assign chain_o = chain_r;

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// ----------------------------------------------------------------------------
// MD5 message digest
// Streaming MD5: bytes in, four digest words out per closed message.
// ----------------------------------------------------------------------------
// A request carrying only a byte that does not complete a 64-byte block is
// taken at once. A byte that completes a block starts a compression (load,
// 64 rounds of a sum step and a mix step on the shared round datapath, and
// the chaining add), during which in_tready is low. A request with tlast set
// adds a pad step, one or two compressions (plus a length step, and a
// clear step when two blocks are needed), then offers the digest as four
// output beats A, B, C, D; the block then restarts at the initial value.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);
  import md5_pkg::*;

  state_t      state_r, state_nxt;
  fin_t        fin_r, fin_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic        end_pend_r, end_pend_nxt;
  logic [1:0]  widx_r, widx_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        out_done;
  logic [5:0]  pos;
  blk_ctl_t    blk_ctl;
  core_op_t    core_op;
  logic [31:0] msg_word;
  words4_t     chain;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;
  assign out_done  = out_acc && (widx_r == LAST_WORD);
  assign pos       = bitcnt_r[8:3];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser && pos == LAST_POS) begin
            state_nxt = S_LOAD;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD:  state_nxt = (pos >= PAD_LIMIT) ? S_LOAD : S_LEN;
      S_CLR:  state_nxt = S_LEN;
      S_LEN:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MIX;
      S_MIX:  state_nxt = S_STEP;
      S_STEP: state_nxt = (round_r == LAST_ROUND) ? S_ACCUM : S_MIX;
      S_ACCUM: begin
        unique case (fin_r)
          FIN_DATA: state_nxt = end_pend_r ? S_PAD : S_IDLE;
          FIN_PAD:  state_nxt = S_CLR;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (out_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid   = (state_r == S_OUT);
    blk_ctl.op   = BLK_NOP;
    blk_ctl.pos  = pos;
    blk_ctl.data = in_tdata;
    blk_ctl.len  = bitcnt_r;
    core_op      = CORE_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser) begin
          blk_ctl.op = BLK_BYTE;
        end
      end
      S_PAD: begin
        blk_ctl.op   = BLK_PAD;
        blk_ctl.data = PAD_BYTE;
      end
      S_CLR:   blk_ctl.op = BLK_CLR;
      S_LEN:   blk_ctl.op = BLK_LEN;
      S_LOAD:  core_op = CORE_LOAD;
      S_MIX:   core_op = CORE_MIX;
      S_STEP:  core_op = CORE_STEP;
      S_ACCUM: core_op = CORE_ACCUM;
      S_OUT: begin
        if (out_done) begin
          core_op = CORE_INIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fin_nxt      = fin_r;
    round_nxt    = round_r;
    bitcnt_nxt   = bitcnt_r;
    end_pend_nxt = end_pend_r;
    widx_nxt     = widx_r;
    if (state_r == S_IDLE) begin
      fin_nxt = FIN_DATA;
      if (in_acc) begin
        end_pend_nxt = in_tlast;
        if (in_tuser) begin
          bitcnt_nxt = bitcnt_r + BITS_PER_BYTE;
        end
      end
    end
    if (state_r == S_PAD) begin
      fin_nxt = FIN_PAD;
    end
    if (state_r == S_LEN) begin
      fin_nxt = FIN_LAST;
    end
    if (state_r == S_LOAD) begin
      round_nxt = '0;
    end
    if (state_r == S_STEP) begin
      round_nxt = round_r + 6'd1;
    end
    if (state_r == S_OUT && out_acc) begin
      widx_nxt = widx_r + 2'd1;
      if (out_done) begin
        bitcnt_nxt   = '0;
        end_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fin_r      <= FIN_DATA;
      round_r    <= '0;
      bitcnt_r   <= '0;
      end_pend_r <= 1'b0;
      widx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fin_r      <= fin_nxt;
      round_r    <= round_nxt;
      bitcnt_r   <= bitcnt_nxt;
      end_pend_r <= end_pend_nxt;
      widx_r     <= widx_nxt;
    end
  end

  md5_blkbuf u_blkbuf (
    .clk       (clk),
    .ctl_i     (blk_ctl),
    .rd_idx_i  (msg_index(round_r)),
    .rd_data_o (msg_word)
  );

  md5_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_i    (core_op),
    .round_i (round_r),
    .msg_i   (msg_word),
    .chain_o (chain)
  );

  assign out_tdata = chain[widx_r];
  assign out_tuser = widx_r;
  assign out_tlast = (widx_r == LAST_WORD);

endmodule

@@ verif/md5_digest_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 digest checker
// Watches the request and digest channels of the MD5 block. It keeps its own
// digest state, queues the four words each closed message must produce and
// compares every digest beat with the oldest queued word.
// ----------------------------------------------------------------------------
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] digest_word
  input  logic [1:0]  out_tuser,  // [1:0] word_index
  input  logic        out_tlast,  // last_word
  output int          fail_count,
  output int          pending,
  output int          words_checked
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
    32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
    32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
    32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
    32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
    32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
    32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
    32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
    32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
    32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
    32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
    32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
    32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
    32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
    32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
    32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
  };

  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22,
    5, 9,  14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  logic [31:0]  chain [4];
  logic [31:0]  blk [16];
  logic [63:0]  bit_total;
  digest_beat_t digest_queue [$];
  digest_beat_t oldest;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic md5_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    foreach (blk[w]) blk[w] = 32'd0;
    bit_total = 64'd0;
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      g = g % 16;
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + ROUND_K[i] + blk[g], ROUND_SHIFT[(i / 16) * 4 + i % 4]);
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endtask

  task automatic md5_place(input int pos, input logic [7:0] v);
    int w, sh;
    w = (pos >> 2) % 16;
    sh = (pos % 4) * 8;
    if (sh == 0) begin
      blk[w] = 32'(v);
    end else begin
      blk[w] |= 32'(v) << sh;
    end
  endtask

  task automatic md5_absorb(input logic [7:0] d, input logic has_byte, input logic last_flag);
    int pos;
    digest_beat_t beat;
    if (has_byte) begin
      pos = int'(bit_total[8:3]);
      md5_place(pos, d);
      bit_total += 64'd8;
      if (pos == 63) md5_compress();
    end
    if (last_flag) begin
      pos = int'(bit_total[8:3]);
      md5_place(pos, 8'h80);
      for (int w = (pos >> 2) + 1; w < 16; w++) blk[w] = 32'd0;
      if (pos >= 56) begin
        md5_compress();
        foreach (blk[w]) blk[w] = 32'd0;
      end
      blk[14] = bit_total[31:0];
      blk[15] = bit_total[63:32];
      md5_compress();
      for (int k = 0; k < 4; k++) begin
        beat.digest_word = chain[k];
        beat.word_index  = 2'(k);
        beat.last_word   = (k == 3);
        digest_queue.push_back(beat);
      end
      md5_restart();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      md5_restart();
      digest_queue.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_queue.size() == 0) begin
          $error("digest word %h arrived with no digest expected", out_tdata);
          fail_count++;
        end else begin
          oldest = digest_queue.pop_front();
          words_checked++;
          if (out_tdata !== oldest.digest_word) begin
            $error("digest_word mismatch: expected %h, actual %h", oldest.digest_word, out_tdata);
            fail_count++;
          end
          if (out_tuser !== oldest.word_index) begin
            $error("word_index mismatch: expected %0d, actual %0d", oldest.word_index, out_tuser);
            fail_count++;
          end
          if (out_tlast !== oldest.last_word) begin
            $error("last_word mismatch: expected %0d, actual %0d", oldest.last_word, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) md5_absorb(in_tdata, in_tuser, in_tlast);
    end
    pending = digest_queue.size();
  end

endmodule

@@ verif/md5_message_digest_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams directed and random messages into the MD5 block under changing
// sender and receiver stalls; a checker beside the block predicts and
// compares every digest word.
// ----------------------------------------------------------------------------
module md5_message_digest_test;

  localparam int LONG_HOLD  = 400;
  localparam int PHASE_REQS = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending;
  int words_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int useful_reqs   = 0;
  int messages_sent = 0;

  md5_message_digest dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  md5_digest_checker digest_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("** md5_message_digest: FAILED **");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(8, 0);
    if (r < 70) return $urandom_range(54, 9);
    if (r < 92) return $urandom_range(66, 52);
    return $urandom_range(130, 100);
  endfunction

  task automatic send_req(input logic [7:0] d, input logic has_byte, input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= has_byte;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (has_byte || last_flag) useful_reqs++;
  endtask

  task automatic send_message(input int len);
    bit fold_end;
    fold_end = ($urandom_range(1) == 1) && (len > 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_req(rand_byte(), 1'b0, 1'b0);
      send_req(rand_byte(), 1'b1, fold_end && (i == len - 1));
    end
    if (!fold_end) send_req(rand_byte(), 1'b0, 1'b1);
    messages_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct);
    int start_reqs, start_msgs;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start_reqs = useful_reqs;
    start_msgs = messages_sent;
    while ((useful_reqs - start_reqs) < PHASE_REQS || (messages_sent - start_msgs) < 2)
      send_message(pick_len());
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, lone zero byte closed on its own request
    send_req(8'h3C, 1'b0, 1'b1);
    send_req(8'h00, 1'b1, 1'b1);
    // ignored request, extremes of the byte, end without byte
    send_req(8'hA5, 1'b0, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h5A, 1'b0, 1'b1);
    send_req(8'h61, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0);
    send_req(8'h63, 1'b1, 1'b1);
    messages_sent += 4;
    drain_results();

    run_phase(34, 87);
    run_phase(87, 34);

    // hold the receiver so the block backs up into its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_message(5);
    send_message(3);
    send_message(12);
    run_phase(0, 0);

    repeat (300) @(posedge clk);
    $display("Run covered %0d requests in %0d messages, %0d digest words checked,",
             useful_reqs, messages_sent, words_checked);
    $display("including empty messages, pad-boundary lengths and a long output stall.");
    if (fail_count == 0) begin
      $display("** md5_message_digest: PASSED **");
    end else begin
      $display("** md5_message_digest: FAILED **");
    end
    $finish;
  end

endmodule
